// ----- hdl/rj192_pkg.sv -----
// Shared types, constants and round functions for the Rijndael-192 encryptor.
`timescale 1ns / 1ps
package rj192_pkg;

    localparam int ROUNDS  = 12;
    localparam int COLS    = 6;
    localparam int BLOCK_W = 32 * COLS;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [7:0]         t_byte;
    typedef logic [31:0]        t_word;

    localparam t_byte RCON [ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36, 8'h6C, 8'hD8
    };

    localparam t_byte SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic t_word sub_word(input t_word w);
        t_word o;
        for (int k = 0; k < 4; k++) begin
            o[8*k +: 8] = SBOX[w[8*k +: 8]];
        end
        return o;
    endfunction

    // Nk = 6 schedule: next six words from the previous six
    function automatic t_block key_next(input t_block k, input t_byte rc);
        t_block n;
        t_word  t;
        t = sub_word({k[167:160], k[191:168]}) ^ {24'h0, rc};
        n[31:0] = k[31:0] ^ t;
        for (int i = 1; i < COLS; i++) begin
            n[32*i +: 32] = k[32*i +: 32] ^ n[32*(i-1) +: 32];
        end
        return n;
    endfunction

    function automatic t_word mix_col(input t_word c);
        t_byte a0, a1, a2, a3;
        a0 = c[7:0];
        a1 = c[15:8];
        a2 = c[23:16];
        a3 = c[31:24];
        return {xtime(a3) ^ xtime(a0) ^ a0 ^ a1 ^ a2,
                xtime(a2) ^ xtime(a3) ^ a3 ^ a0 ^ a1,
                xtime(a1) ^ xtime(a2) ^ a2 ^ a0 ^ a3,
                xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3};
    endfunction

    function automatic t_block cipher_round(input t_block s, input t_block k,
                                            input logic last);
        t_block t;
        for (int c = 0; c < COLS; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[32*c + 8*r +: 8] = SBOX[s[32*((c + r) % COLS) + 8*r +: 8]];
            end
        end
        if (!last) begin
            for (int c = 0; c < COLS; c++) begin
                t[32*c +: 32] = mix_col(t[32*c +: 32]);
            end
        end
        return t ^ k;
    endfunction

endpackage

// ----- hdl/rijndael192_block_encrypt.sv -----
// Top level: Rijndael-192 block encryptor, fully pipelined over 12 rounds.
`timescale 1ns / 1ps
// Usage:
//   Key: write key_low/key_mid/key_high through the config channel
//   (index 0/1/2, others ignored). o_cfg_ready is always high. The round
//   keys are derived stage by stage alongside each block, so a block uses
//   the key held when it is accepted.
//   Input: plaintext transfer on i_valid/o_ready, three 64-bit words.
//   Output: ciphertext on o_valid/i_ready, three 64-bit words.
//   Pipeline: one whitening stage plus one register stage per round; o_valid
//   rises once the block is held in the last round register.
//   Throughput: one block per cycle while the output is not stalled; 13 blocks in flight.
//   Stalls: each stage holds while its successor is full and stalled;
//   bubbles collapse, nothing is lost or repeated.
//   Reset: synchronous, clears all stage valids and the key to zero.
module rijndael192_block_encrypt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_plain_low,
    input  logic [63:0] i_plain_mid,
    input  logic [63:0] i_plain_high,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_cipher_low,
    output logic [63:0] o_cipher_mid,
    output logic [63:0] o_cipher_high
);
    import rj192_pkg::*;

    localparam logic [1:0] IDX_LOW  = 2'd0;
    localparam logic [1:0] IDX_MID  = 2'd1;
    localparam logic [1:0] IDX_HIGH = 2'd2;

    t_block r_key;
    logic   r_valid0;
    t_block r_state0, r_key0;

    logic   v   [ROUNDS+1];
    logic   rdy [ROUNDS+1];
    t_block st  [ROUNDS+1];
    t_block ky  [ROUNDS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                IDX_LOW:  r_key[63:0]    <= i_cfg_data;
                IDX_MID:  r_key[127:64]  <= i_cfg_data;
                IDX_HIGH: r_key[191:128] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready = !r_valid0 || rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (o_ready) begin
            r_valid0 <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_key0   <= r_key;
            r_state0 <= {i_plain_high, i_plain_mid, i_plain_low} ^ r_key;
        end
    end

    assign v[0]  = r_valid0;
    assign st[0] = r_state0;
    assign ky[0] = r_key0;

    for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
        rj192_round #(.ROUND(g)) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v[g-1]),
            .o_ready (rdy[g]),
            .i_state (st[g-1]),
            .i_key   (ky[g-1]),
            .o_valid (v[g]),
            .i_ready (g == ROUNDS ? i_ready : rdy[g+1 > ROUNDS ? ROUNDS : g+1]),
            .o_state (st[g]),
            .o_key   (ky[g])
        );
    end

    assign rdy[0]        = o_ready;
    assign o_valid       = v[ROUNDS];
    assign o_cipher_low  = st[ROUNDS][63:0];
    assign o_cipher_mid  = st[ROUNDS][127:64];
    assign o_cipher_high = st[ROUNDS][191:128] ^ (ky[ROUNDS][191:128] & '0);

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid straight after reset");
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid0 && !rdy[1] |-> !o_ready)
        else $error("input taken while first stage blocked");
    a_cfg_ignore: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && i_cfg_index != IDX_LOW && i_cfg_index != IDX_MID
        && i_cfg_index != IDX_HIGH |=> $stable(r_key))
        else $error("key changed on unknown index");
endmodule

// ----- hdl/rj192_round.sv -----
// One registered cipher round with its on-the-fly round key step.
`timescale 1ns / 1ps
module rj192_round #(
    parameter int ROUND = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rj192_pkg::t_block i_state,
    input  rj192_pkg::t_block i_key,
    output logic             o_valid,
    input  logic             i_ready,
    output rj192_pkg::t_block o_state,
    output rj192_pkg::t_block o_key
);
    import rj192_pkg::*;

    logic   r_valid;
    t_block r_state, r_key;
    t_block n_key;

    assign o_ready = !r_valid || i_ready;
    assign n_key   = key_next(i_key, RCON[ROUND-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_key   <= n_key;
            r_state <= cipher_round(i_state, n_key, ROUND == ROUNDS);
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_state) && $stable(r_key))
        else $error("stalled round stage changed");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid && i_valid |=> r_valid)
        else $error("empty round stage did not take transfer");
endmodule
